### rtl/ssa_pkg.sv
package ssa_pkg;

  localparam int MaxSeatsDefault = 16384;

  typedef enum logic [2:0] {
    CMD_RESERVE = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_QUERY   = 3'd2,
    CMD_OPEN    = 3'd3,
    CMD_CLOSE   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CLOSED   = 3'd1,
    ST_OPEN     = 3'd2,
    ST_PERSON   = 3'd3,
    ST_SEAT     = 3'd4,
    ST_FULL     = 3'd5,
    ST_EMPTY    = 3'd6,
    ST_CAPACITY = 3'd7
  } status_e;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] person_id;
    logic [15:0]        seat_id;
    logic [15:0]        capacity;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [14:0] seat_number;
    logic [30:0] owner_id;
    logic [14:0] free_count;
    logic [14:0] occupied_count;
    logic [14:0] room_size;
  } res_word_t;

endpackage

### rtl/ssa_bitmap.sv
// Two-level free bitmap: 64-bit leaf words in a memory, one summary bit per
// leaf word in flip-flops. A live bit per leaf word stands in for clearing the
// leaf memory: a word that is not live reads as all free.
module ssa_bitmap import ssa_pkg::*; #(
  parameter int MaxSeats = MaxSeatsDefault,
  localparam int Words = (MaxSeats + 63) / 64,
  localparam int IdxW  = (Words > 1) ? $clog2(Words) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic                       rd_en,
  input  logic [IdxW-1:0]            rd_idx,
  output logic [63:0]                rd_data,
  input  logic                       wr_en,
  input  logic [IdxW-1:0]            wr_idx,
  input  logic [63:0]                wr_data,
  output logic [Words-1:0]           full_words
);
  logic [63:0]      mem [Words];
  logic [Words-1:0] word_live;
  logic [63:0]      q_data;
  logic             q_live;

  // Drop all live and full marks on clear; mark a word live once written
  always_ff @(posedge clk) begin
    if (rst) begin
      full_words <= '0;
      word_live  <= '0;
    end else if (clear) begin
      full_words <= '0;
      word_live  <= '0;
    end else if (wr_en) begin
      full_words[wr_idx] <= &wr_data;
      word_live[wr_idx]  <= 1'b1;
    end
  end

  // Write and read leaf words
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    if (rd_en) q_data <= mem[rd_idx];
  end

  // Hold the live mark of the word just read
  always_ff @(posedge clk) begin
    if (rst) q_live <= 1'b0;
    else if (rd_en) q_live <= word_live[rd_idx];
  end

  assign rd_data = q_live ? q_data : '0;
endmodule

### rtl/ssa_owner_ram.sv
// Owner id per slot, one read port, one write port, registered read
module ssa_owner_ram import ssa_pkg::*; #(
  parameter int MaxSeats = MaxSeatsDefault,
  localparam int AW = (MaxSeats > 1) ? $clog2(MaxSeats) : 1
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [30:0]                 rd_data,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [30:0]                 wr_data
);
  logic [30:0] mem [MaxSeats];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule

### rtl/seat_slot_allocator_unit.sv
// Channel   Ports                      Handshake
// command   start, busy, cmd           taken when start && !busy
// result    done, res                  valid for one cycle while done is high
//
// Every command passes S_READ, S_MOD and S_OUT from acceptance to the edge
// that takes the result (issue read, take memory data, write back, deliver);
// the leaf-word and owner memory reads set this. busy is high in those states;
// done, registered from S_OUT, is high once idle again, and a new command can
// be taken at that cycle's closing edge. Reset and every valid open drop the
// per-word live bits at once; no clearing pass. The receiver cannot stall.
module seat_slot_allocator_unit import ssa_pkg::*; #(
  parameter int MaxSeats = MaxSeatsDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  cmd_word_t cmd,
  output logic      done,
  output res_word_t res
);
  localparam int Words = (MaxSeats + 63) / 64;
  localparam int IdxW  = (Words > 1) ? $clog2(Words) : 1;
  localparam int AW    = (MaxSeats > 1) ? $clog2(MaxSeats) : 1;
  localparam int CW    = $clog2(MaxSeats + 1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_MOD, S_OUT} state_e;

  state_e      state;
  cmd_word_t   c;
  logic        room_open;
  logic [CW-1:0] slot_total, taken_total;
  logic [2:0]  status;
  logic [14:0] seat_out;
  logic        act;
  logic [IdxW-1:0] word_idx;
  logic [AW-1:0]   seat_addr;

  logic [63:0] rd_word;
  logic [Words-1:0] full_words;
  logic [30:0] owner_q;
  logic [30:0] owner_hold;
  logic        clear;

  // Lowest non-full leaf word
  logic [IdxW-1:0] first_word;
  always_comb begin
    first_word = '0;
    for (int i = Words - 1; i >= 0; i--) begin
      if (!full_words[i]) first_word = IdxW'(i);
    end
  end

  // Lowest free bit within the read leaf word
  logic [5:0] first_bit;
  always_comb begin
    first_bit = '0;
    for (int i = 63; i >= 0; i--) begin
      if (!rd_word[i]) first_bit = 6'(i);
    end
  end

  logic pid_ok, seat_ok;
  assign pid_ok  = (cmd.person_id != 0) && !cmd.person_id[31];
  assign seat_ok = (cmd.seat_id != 0) && (32'(cmd.seat_id) <= 32'(slot_total));

  logic [AW-1:0] seat_m1;
  assign seat_m1 = AW'(cmd.seat_id - 16'd1);

  logic [IdxW+5:0] found_slot;
  assign found_slot = {word_idx, first_bit};

  logic        bm_wr;
  logic [63:0] bm_wdata;
  logic        own_wr;
  logic        own_rd;
  assign own_rd = (state == S_IDLE) && start;

  ssa_bitmap #(.MaxSeats(MaxSeats)) u_bitmap (
    .clk, .rst, .clear,
    .rd_en(own_rd),
    .rd_idx(cmd.command == CMD_RESERVE ? first_word : IdxW'(seat_m1 >> 6)),
    .rd_data(rd_word),
    .wr_en(bm_wr), .wr_idx(word_idx), .wr_data(bm_wdata),
    .full_words
  );

  ssa_owner_ram #(.MaxSeats(MaxSeats)) u_owner (
    .clk,
    .rd_en(own_rd), .rd_addr(seat_m1), .rd_data(owner_q),
    .wr_en(own_wr), .wr_addr(AW'(found_slot)), .wr_data(c.person_id[30:0])
  );

  // Modify step: leaf word and owner updates
  always_comb begin
    bm_wr    = 1'b0;
    own_wr   = 1'b0;
    bm_wdata = rd_word;
    if (state == S_MOD && act) begin
      if (c.command == CMD_RESERVE) begin
        bm_wr = 1'b1;
        own_wr = 1'b1;
        bm_wdata[first_bit] = 1'b1;
      end else if (c.command == CMD_RELEASE && rd_word[seat_addr[5:0]]) begin
        bm_wr = 1'b1;
        bm_wdata[seat_addr[5:0]] = 1'b0;
      end
    end
  end

  assign clear = (state == S_IDLE) && start && !room_open && (cmd.command == CMD_OPEN) &&
                 cmd.capacity != 0 && 32'(cmd.capacity) <= MaxSeats;

  assign busy = (state != S_IDLE);

  // Sequence one command and hold room state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      room_open   <= 1'b0;
      slot_total  <= '0;
      taken_total <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          c         <= cmd;
          seat_addr <= seat_m1;
          word_idx  <= cmd.command == CMD_RESERVE ? first_word : IdxW'(seat_m1 >> 6);
          seat_out  <= '0;
          act       <= 1'b0;
          status    <= ST_OK;
          case (cmd.command)
            CMD_RESERVE: begin
              if (!room_open) status <= ST_CLOSED;
              else if (!pid_ok) status <= ST_PERSON;
              else if (taken_total >= slot_total) status <= ST_FULL;
              else act <= 1'b1;
            end
            CMD_RELEASE, CMD_QUERY: begin
              if (!room_open) status <= ST_CLOSED;
              else if (!seat_ok) status <= ST_SEAT;
              else act <= 1'b1;
            end
            CMD_OPEN: begin
              if (room_open) status <= ST_OPEN;
              else if (!clear) status <= ST_CAPACITY;
              else begin
                room_open   <= 1'b1;
                slot_total  <= CW'(cmd.capacity);
                taken_total <= '0;
              end
            end
            CMD_CLOSE: begin
              if (!room_open) status <= ST_CLOSED;
              else begin
                room_open   <= 1'b0;
                slot_total  <= '0;
                taken_total <= '0;
              end
            end
            default: ;
          endcase
          state <= S_READ;
        end
        S_READ: state <= S_MOD;
        S_MOD: begin
          if (act) begin
            if (c.command == CMD_RESERVE) begin
              seat_out    <= 15'(found_slot) + 15'd1;
              taken_total <= taken_total + 1'b1;
            end else if (!rd_word[seat_addr[5:0]]) begin
              status <= ST_EMPTY;
            end else if (c.command == CMD_RELEASE) begin
              taken_total <= taken_total - 1'b1;
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Shape the result word
  always_comb begin
    res.status         = status;
    res.seat_number    = seat_out;
    res.owner_id       = (act && status == ST_OK && c.command != CMD_RESERVE) ?
                         owner_hold : '0;
    res.free_count     = 15'(slot_total - taken_total);
    res.occupied_count = 15'(taken_total);
    res.room_size      = 15'(slot_total);
  end

  // Capture the owner read in the modify step
  always_ff @(posedge clk) begin
    if (state == S_MOD) owner_hold <= owner_q;
  end
endmodule
